@@ rtl/rdcm_pkg.sv @@
// ----------------------------------------------------------------------------
// rdcm_pkg: shared types and constants of the remote drive command mapper
// Field widths, fixed ranges, register indexes, codes and state types.
// ----------------------------------------------------------------------------
package rdcm_pkg;

  // field widths
  localparam int unsigned ID_W    = 29;
  localparam int unsigned BTN_W   = 10;
  localparam int unsigned STICK_W = 8;
  localparam int unsigned SPEED_W = 10;  // speed registers
  localparam int unsigned RATE_W  = 17;  // scaled speeds, up to 100 * 1023
  localparam int unsigned PROD_W  = STICK_W + RATE_W;  // |x-a| * |d-c|
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CNT_W   = 5;

  // serial step counts
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(STICK_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  // fixed values
  localparam logic [ID_W-1:0]    REMOTE_FRAME_ID = 29'd256;
  localparam logic [SPEED_W-1:0] BRUSH_MIN_SPEED = 10'd0;
  localparam logic [STICK_W-1:0] POT_MIN         = 8'd0;
  localparam logic [STICK_W-1:0] POT_MAX         = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 3'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN       = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET     = 3'd3;
  localparam logic [RATE_W-1:0]  SCALE           = 17'd100;
  localparam logic [RATE_W-1:0]  TRACK_SCALE     = 17'd20;  // SCALE / LEVEL_MAX

  // button bit positions
  localparam int unsigned BTN_UP     = 0;
  localparam int unsigned BTN_DOWN   = 1;
  localparam int unsigned BTN_RNORTH = 2;
  localparam int unsigned BTN_RSOUTH = 3;
  localparam int unsigned BTN_LNORTH = 4;
  localparam int unsigned BTN_LSOUTH = 5;
  localparam int unsigned BTN_CW     = 6;
  localparam int unsigned BTN_CCW    = 7;
  localparam int unsigned BTN_PUMP   = 8;
  localparam int unsigned BTN_STOP   = 9;

  // direction and pump codes
  localparam logic [1:0] DIR_KEEP    = 2'd0;
  localparam logic [1:0] DIR_FWD     = 2'd1;
  localparam logic [1:0] DIR_REV     = 2'd2;
  localparam logic [1:0] PUMP_NONE   = 2'd0;
  localparam logic [1:0] PUMP_OFF    = 2'd1;
  localparam logic [1:0] PUMP_TOGGLE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE   = 4'd0,
    REG_STICK_MIN   = 4'd1,
    REG_STICK_MAX   = 4'd2,
    REG_RIGHT_MIN   = 4'd3,
    REG_RIGHT_MAX   = 4'd4,
    REG_LEFT_MIN    = 4'd5,
    REG_LEFT_MAX    = 4'd6,
    REG_BRUSH_MAX   = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_START,
    TOP_WAIT,
    TOP_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_MUL,
    LANE_DIV,
    LANE_FIN
  } lane_state_e;

  // operands of one linear map: (x-a)*(d-c)/(b-a)+c
  typedef struct packed {
    logic               start;
    logic               en;     // outside the dead zone
    logic [STICK_W-1:0] x;
    logic [STICK_W-1:0] a;
    logic [STICK_W-1:0] b;
    logic [RATE_W-1:0]  c;
    logic [RATE_W-1:0]  d;
  } lane_req_t;

  typedef struct packed {
    logic             busy;
    logic [OUT_W-1:0] res;
  } lane_rsp_t;

  function automatic logic [1:0] pair_dir(input logic fwd, input logic rev);
    logic [1:0] dir;
    dir = DIR_KEEP;
    if (fwd && !rev) dir = DIR_FWD;
    if (rev && !fwd) dir = DIR_REV;
    return dir;
  endfunction

  function automatic logic [RATE_W-1:0] scale_min(input logic [SPEED_W-1:0] v);
    return RATE_W'(RATE_W'(v) * SCALE);
  endfunction

endpackage

@@ rtl/rdcm_lane.sv @@
// ----------------------------------------------------------------------------
// rdcm_lane: bit-serial linear map
// Shift-add multiply of the magnitudes, one bit a cycle, then a restoring
// divide, one quotient bit a cycle; sign, offset and 16 bit wrap at the end.
// ----------------------------------------------------------------------------
module rdcm_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rdcm_pkg::lane_req_t  req_i,
  output rdcm_pkg::lane_rsp_t  rsp_o
);

  rdcm_pkg::lane_state_e state_q, state_d;
  logic [rdcm_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  logic [rdcm_pkg::STICK_W-1:0] dx_q, dx_d;
  logic [rdcm_pkg::RATE_W-1:0]  rng_q, rng_d;
  logic [rdcm_pkg::STICK_W-1:0] span_q, span_d;
  logic [rdcm_pkg::PROD_W-1:0]  acc_q, acc_d;
  logic [rdcm_pkg::STICK_W-1:0] rem_q, rem_d;
  logic [rdcm_pkg::OUT_W-1:0]   quo_q, quo_d;
  logic [rdcm_pkg::OUT_W-1:0]   off_q, off_d;
  logic [rdcm_pkg::OUT_W-1:0]   res_q, res_d;
  logic                         neg_q, neg_d;
  logic                         zero_q, zero_d;

  // set-up arithmetic
  logic [rdcm_pkg::STICK_W:0]   dx_s, dx_n, span_s, span_n;
  logic [rdcm_pkg::RATE_W:0]    rng_s, rng_n;
  // divide step
  logic [rdcm_pkg::STICK_W:0]   trial;
  logic [rdcm_pkg::STICK_W+1:0] diff;
  logic                         qbit;
  logic [rdcm_pkg::OUT_W-1:0]   quo_sgn;

  always_comb begin
    dx_s   = {1'b0, req_i.x} - {1'b0, req_i.a};
    span_s = {1'b0, req_i.b} - {1'b0, req_i.a};
    rng_s  = {1'b0, req_i.d} - {1'b0, req_i.c};
    dx_n   = -dx_s;
    span_n = -span_s;
    rng_n  = -rng_s;

    trial = {rem_q, acc_q[rdcm_pkg::PROD_W-1]};
    diff  = {1'b0, trial} - {2'b00, span_q};
    qbit  = ~diff[rdcm_pkg::STICK_W+1];

    quo_sgn = neg_q ? -quo_q : quo_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dx_d    = dx_q;
    rng_d   = rng_q;
    span_d  = span_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    off_d   = off_q;
    res_d   = res_q;
    neg_d   = neg_q;
    zero_d  = zero_q;
    case (state_q)
      rdcm_pkg::LANE_IDLE: begin
        if (req_i.start) begin
          dx_d   = dx_s[rdcm_pkg::STICK_W] ? dx_n[rdcm_pkg::STICK_W-1:0]
                                           : dx_s[rdcm_pkg::STICK_W-1:0];
          span_d = span_s[rdcm_pkg::STICK_W] ? span_n[rdcm_pkg::STICK_W-1:0]
                                             : span_s[rdcm_pkg::STICK_W-1:0];
          rng_d  = rng_s[rdcm_pkg::RATE_W] ? rng_n[rdcm_pkg::RATE_W-1:0]
                                           : rng_s[rdcm_pkg::RATE_W-1:0];
          neg_d  = dx_s[rdcm_pkg::STICK_W] ^ span_s[rdcm_pkg::STICK_W]
                 ^ rng_s[rdcm_pkg::RATE_W];
          zero_d = !req_i.en || (span_s == '0);
          off_d  = req_i.c[rdcm_pkg::OUT_W-1:0];
          acc_d  = '0;
          rem_d  = '0;
          quo_d  = '0;
          cnt_d  = '0;
          state_d = rdcm_pkg::LANE_MUL;
        end
      end
      rdcm_pkg::LANE_MUL: begin
        // MSB first over |x-a|
        acc_d = {acc_q[rdcm_pkg::PROD_W-2:0], 1'b0}
              + (dx_q[rdcm_pkg::STICK_W-1] ? rdcm_pkg::PROD_W'(rng_q) : '0);
        dx_d  = {dx_q[rdcm_pkg::STICK_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rdcm_pkg::MUL_LAST) begin
          cnt_d   = '0;
          state_d = rdcm_pkg::LANE_DIV;
        end
      end
      rdcm_pkg::LANE_DIV: begin
        // product shifts out MSB first; only the low quotient bits matter
        acc_d = {acc_q[rdcm_pkg::PROD_W-2:0], 1'b0};
        rem_d = qbit ? diff[rdcm_pkg::STICK_W-1:0] : trial[rdcm_pkg::STICK_W-1:0];
        quo_d = {quo_q[rdcm_pkg::OUT_W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rdcm_pkg::DIV_LAST) begin
          cnt_d   = '0;
          state_d = rdcm_pkg::LANE_FIN;
        end
      end
      rdcm_pkg::LANE_FIN: begin
        res_d   = zero_q ? '0 : quo_sgn + off_q;
        state_d = rdcm_pkg::LANE_IDLE;
      end
      default: begin
        state_d = rdcm_pkg::LANE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdcm_pkg::LANE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    rng_q  <= rng_d;
    span_q <= span_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    off_q  <= off_d;
    res_q  <= res_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign rsp_o.busy = (state_q != rdcm_pkg::LANE_IDLE);
  assign rsp_o.res  = res_q;

endmodule

@@ rtl/remote_drive_command_mapper.sv @@
// ----------------------------------------------------------------------------
// remote_drive_command_mapper: remote frame to drive commands
// Speed level, track and brush speeds, directions and pump request.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one decoded frame a beat; the
// output channel (out_valid_o/out_ready_i) gives one result beat per frame.
// Configuration writes come on cfg_valid_i/cfg_index_i/cfg_data_i, always
// ready; the user must make them only while no frame is in flight, as the
// block does not enforce this; indexes above 7 are dropped.
// Frames are handled one at a time. A matching frame runs through three
// bit-serial map lanes side by side: 8 multiply steps and 25 divide steps,
// plus set-up, finish and output load. A frame with another id skips the
// lanes and goes straight to the output load. A new frame is taken only
// once the previous one has been loaded into the output register.
// The output beat sits in its own register, so the next frame is taken while
// the receiver stalls; a finished frame then waits until the register frees.
// Reset clears the level to 3, the button history and the registers to their
// defaults, with no output beat pending.
// ----------------------------------------------------------------------------
module remote_drive_command_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // frame in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [28:0] frame_id_i,
  input  logic [9:0]  buttons_i,
  input  logic [7:0]  right_stick_i,
  input  logic [7:0]  left_stick_i,
  input  logic [7:0]  brush_pot_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  speed_level_o,
  output logic [15:0] right_speed_o,
  output logic [1:0]  right_direction_o,
  output logic [15:0] left_speed_o,
  output logic [1:0]  left_direction_o,
  output logic [15:0] brush_speed_o,
  output logic [1:0]  brush_direction_o,
  output logic [1:0]  pump_request_o
);

  // configuration registers
  logic [rdcm_pkg::STICK_W-1:0] dead_zone_q, stick_min_q, stick_max_q;
  logic [rdcm_pkg::SPEED_W-1:0] right_min_q, right_max_q;
  logic [rdcm_pkg::SPEED_W-1:0] left_min_q, left_max_q, brush_max_q;

  // state
  rdcm_pkg::top_state_e state_q, state_d;
  logic [rdcm_pkg::LEVEL_W-1:0] level_q, level_d;
  logic last_up_q, last_up_d, last_dn_q, last_dn_d, last_pump_q, last_pump_d;

  // captured frame
  logic [rdcm_pkg::BTN_W-1:0]   btn_q;
  logic [rdcm_pkg::STICK_W-1:0] rs_q, ls_q, bp_q;
  logic                         match_q;
  logic [1:0]                   pump_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        acc_out_q;
  logic [2:0]  lvl_out_q;
  logic [15:0] rspd_q, lspd_q, bspd_q;
  logic [1:0]  rdir_q, ldir_q, bdir_q, pump_out_q;

  logic accept, match, load, lanes_busy;
  logic up, down, pump, stop;
  logic [1:0] pump_req;

  rdcm_pkg::lane_req_t req_r, req_l, req_b;
  rdcm_pkg::lane_rsp_t rsp_r, rsp_l, rsp_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= 8'd10;
      stick_min_q <= 8'd0;
      stick_max_q <= 8'd255;
      right_min_q <= 10'd0;
      right_max_q <= 10'd30;
      left_min_q  <= 10'd0;
      left_max_q  <= 10'd30;
      brush_max_q <= 10'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rdcm_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg_data_i[rdcm_pkg::STICK_W-1:0];
        rdcm_pkg::REG_STICK_MIN: stick_min_q <= cfg_data_i[rdcm_pkg::STICK_W-1:0];
        rdcm_pkg::REG_STICK_MAX: stick_max_q <= cfg_data_i[rdcm_pkg::STICK_W-1:0];
        rdcm_pkg::REG_RIGHT_MIN: right_min_q <= cfg_data_i;
        rdcm_pkg::REG_RIGHT_MAX: right_max_q <= cfg_data_i;
        rdcm_pkg::REG_LEFT_MIN:  left_min_q  <= cfg_data_i;
        rdcm_pkg::REG_LEFT_MAX:  left_max_q  <= cfg_data_i;
        rdcm_pkg::REG_BRUSH_MAX: brush_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == rdcm_pkg::TOP_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign match      = (frame_id_i == rdcm_pkg::REMOTE_FRAME_ID);
  assign up         = buttons_i[rdcm_pkg::BTN_UP];
  assign down       = buttons_i[rdcm_pkg::BTN_DOWN];
  assign pump       = buttons_i[rdcm_pkg::BTN_PUMP];
  assign stop       = buttons_i[rdcm_pkg::BTN_STOP];
  assign lanes_busy = rsp_r.busy || rsp_l.busy || rsp_b.busy;
  assign load       = (state_q == rdcm_pkg::TOP_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    pump_req = rdcm_pkg::PUMP_NONE;
    if (stop) begin
      pump_req = rdcm_pkg::PUMP_OFF;
    end else if (pump && !last_pump_q) begin
      pump_req = rdcm_pkg::PUMP_TOGGLE;
    end
  end

  // level and button history move only on a matching frame
  always_comb begin
    level_d     = level_q;
    last_up_d   = last_up_q;
    last_dn_d   = last_dn_q;
    last_pump_d = last_pump_q;
    if (accept && match) begin
      if (up && !last_up_q) begin
        level_d = (level_q < rdcm_pkg::LEVEL_MAX) ? level_q + 1'b1 : rdcm_pkg::LEVEL_MAX;
      end else if (down && !last_dn_q) begin
        level_d = (level_q > rdcm_pkg::LEVEL_MIN) ? level_q - 1'b1 : rdcm_pkg::LEVEL_MIN;
      end
      last_up_d = up;
      last_dn_d = down;
      if (!stop) begin
        last_pump_d = pump;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rdcm_pkg::TOP_IDLE: begin
        if (accept) begin
          state_d = match ? rdcm_pkg::TOP_START : rdcm_pkg::TOP_OUT;
        end
      end
      rdcm_pkg::TOP_START: state_d = rdcm_pkg::TOP_WAIT;
      rdcm_pkg::TOP_WAIT: begin
        if (!lanes_busy) begin
          state_d = rdcm_pkg::TOP_OUT;
        end
      end
      rdcm_pkg::TOP_OUT: begin
        if (load) begin
          state_d = rdcm_pkg::TOP_IDLE;
        end
      end
      default: state_d = rdcm_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdcm_pkg::TOP_IDLE;
      level_q     <= rdcm_pkg::LEVEL_RESET;
      last_up_q   <= 1'b0;
      last_dn_q   <= 1'b0;
      last_pump_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      last_up_q   <= last_up_d;
      last_dn_q   <= last_dn_d;
      last_pump_q <= last_pump_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      btn_q   <= buttons_i;
      rs_q    <= right_stick_i;
      ls_q    <= left_stick_i;
      bp_q    <= brush_pot_i;
      match_q <= match;
      pump_q  <= pump_req;
    end
  end

  // lane operands, held from the captured frame
  always_comb begin
    req_r.start = (state_q == rdcm_pkg::TOP_START);
    req_r.en    = rs_q > dead_zone_q;
    req_r.x     = rs_q;
    req_r.a     = stick_min_q;
    req_r.b     = stick_max_q;
    req_r.c     = rdcm_pkg::scale_min(right_min_q);
    req_r.d     = rdcm_pkg::RATE_W'(rdcm_pkg::RATE_W'(right_max_q)
                * rdcm_pkg::TRACK_SCALE * rdcm_pkg::RATE_W'(level_q));

    req_l.start = (state_q == rdcm_pkg::TOP_START);
    req_l.en    = ls_q > dead_zone_q;
    req_l.x     = ls_q;
    req_l.a     = stick_min_q;
    req_l.b     = stick_max_q;
    req_l.c     = rdcm_pkg::scale_min(left_min_q);
    req_l.d     = rdcm_pkg::RATE_W'(rdcm_pkg::RATE_W'(left_max_q)
                * rdcm_pkg::TRACK_SCALE * rdcm_pkg::RATE_W'(level_q));

    req_b.start = (state_q == rdcm_pkg::TOP_START);
    req_b.en    = bp_q > dead_zone_q;
    req_b.x     = bp_q;
    req_b.a     = rdcm_pkg::POT_MIN;
    req_b.b     = rdcm_pkg::POT_MAX;
    req_b.c     = rdcm_pkg::scale_min(rdcm_pkg::BRUSH_MIN_SPEED);
    req_b.d     = rdcm_pkg::scale_min(brush_max_q);
  end

  rdcm_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_r),
    .rsp_o  (rsp_r)
  );

  rdcm_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_l),
    .rsp_o  (rsp_l)
  );

  rdcm_lane u_lane_brush (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_b),
    .rsp_o  (rsp_b)
  );

  // output register load; for a rejected frame everything is zero but the level
  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_out_q  <= match_q;
      lvl_out_q  <= level_q;
      rspd_q     <= match_q ? rsp_r.res : '0;
      lspd_q     <= match_q ? rsp_l.res : '0;
      bspd_q     <= match_q ? rsp_b.res : '0;
      rdir_q     <= match_q ? rdcm_pkg::pair_dir(btn_q[rdcm_pkg::BTN_RSOUTH],
                                                 btn_q[rdcm_pkg::BTN_RNORTH])
                            : rdcm_pkg::DIR_KEEP;
      ldir_q     <= match_q ? rdcm_pkg::pair_dir(btn_q[rdcm_pkg::BTN_LNORTH],
                                                 btn_q[rdcm_pkg::BTN_LSOUTH])
                            : rdcm_pkg::DIR_KEEP;
      bdir_q     <= match_q ? rdcm_pkg::pair_dir(btn_q[rdcm_pkg::BTN_CCW],
                                                 btn_q[rdcm_pkg::BTN_CW])
                            : rdcm_pkg::DIR_KEEP;
      pump_out_q <= match_q ? pump_q : rdcm_pkg::PUMP_NONE;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_out_q;
  assign speed_level_o     = lvl_out_q;
  assign right_speed_o     = rspd_q;
  assign right_direction_o = rdir_q;
  assign left_speed_o      = lspd_q;
  assign left_direction_o  = ldir_q;
  assign brush_speed_o     = bspd_q;
  assign brush_direction_o = bdir_q;
  assign pump_request_o    = pump_out_q;

endmodule

@@ rtl/rdcm_checker.sv @@
// ----------------------------------------------------------------------------
// rdcm_checker: port-level checks of the remote drive command mapper
// Watches the top level's ports; attached by the bind at the end.
// ----------------------------------------------------------------------------
module rdcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic [2:0]  speed_level_o,
  input logic [15:0] right_speed_o,
  input logic [1:0]  right_direction_o,
  input logic [15:0] left_speed_o,
  input logic [1:0]  left_direction_o,
  input logic [15:0] brush_speed_o,
  input logic [1:0]  brush_direction_o,
  input logic [1:0]  pump_request_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(speed_level_o)
      && $stable(right_speed_o) && $stable(left_speed_o) && $stable(brush_speed_o)
      && $stable(accepted_o) && $stable(pump_request_o))
    else $error("result beat changed while stalled");

  // one frame at a time
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("frame taken while another is in flight");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_level_o >= 3'd1 && speed_level_o <= 3'd5)
    else $error("speed level out of range");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> right_speed_o == 16'd0 && left_speed_o == 16'd0
      && brush_speed_o == 16'd0 && right_direction_o == 2'd0
      && left_direction_o == 2'd0 && brush_direction_o == 2'd0
      && pump_request_o == 2'd0)
    else $error("rejected frame carries commands");

  // a new result beat never rises straight after a frame is accepted
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_o) |-> !(out_valid_o && !$past(out_valid_o)))
    else $error("result beat appeared the cycle after its frame");

endmodule

bind remote_drive_command_mapper rdcm_checker u_rdcm_checker (.*);
